// File: design/gru_pkg.sv
// ----------------------------------------------------------------------------
// gru_pkg: shared types and constants
// Item layouts, command codes and fixed-point constants for the rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gru_pkg;

    localparam int PORT_W          = 32;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_CS         = 30;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    localparam logic CMD_COMPUTE = 1'b0;
    localparam logic CMD_APPLY   = 1'b1;

    localparam int DIV_NUM_W  = 62;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_QUOT_W = 31;

    typedef struct packed {
        logic               command;
        logic signed [31:0] first_in;
        logic signed [31:0] second_in;
    } gru_in_t;

    typedef struct packed {
        logic signed [31:0] first_out;
        logic signed [31:0] second_out;
        logic signed [31:0] cos_out;
        logic signed [31:0] sin_out;
    } gru_out_t;

endpackage

`default_nettype wire

// File: design/gru_div.sv
// ----------------------------------------------------------------------------
// gru_div: restoring divider
// One quotient bit per cycle; quotient known to fit in DIV_QUOT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gru_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [gru_pkg::DIV_NUM_W-1:0]    num,
    input  wire logic [gru_pkg::DIV_DEN_W-1:0]    den,
    output logic                                  done,
    output logic      [gru_pkg::DIV_QUOT_W-1:0]   quot
);

    localparam int QW = gru_pkg::DIV_QUOT_W;
    localparam int DW = gru_pkg::DIV_DEN_W;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [DW:0]       rem_reg;
    logic [QW-1:0]     nsh_reg;
    logic [QW-1:0]     quot_reg;
    logic [DW-1:0]     den_reg;

    logic [DW:0]       rem_sh;
    logic              ge;
    logic [DW:0]       rem_next;

    assign rem_sh   = {rem_reg[DW-1:0], nsh_reg[QW-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= {{(DW+1-QW){1'b0}}, num[gru_pkg::DIV_NUM_W-1:QW]};
                nsh_reg  <= num[QW-1:0];
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                nsh_reg  <= {nsh_reg[QW-2:0], 1'b0};
                quot_reg <= {quot_reg[QW-2:0], ge};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: design/givens_rotation_unit.sv
// ----------------------------------------------------------------------------
// givens_rotation_unit: Givens rotation engine
// Computes (h, cos, sin) from a pivot pair and applies the stored rotation.
// ----------------------------------------------------------------------------
//  channel | ports                  | payload
//  input   | s_valid s_ready s_data | gru_in_t  (command, first_in, second_in)
//  result  | m_valid m_ready m_data | gru_out_t (first_out, second_out, cos, sin)
//
//  Apply item: from accept to result, 4 passes of the shared 32x32 multiplier,
//  one accumulate, then one output load once the result register is free.
//  Compute item: 2 multiplies, 32 square-root steps, then two 31-step
//  divisions (cos, sin), or none when the pivots are both zero.
//  One item at a time; s_ready is low from accept until the result is loaded.
//  A new item is taken while the result register still waits on m_ready.
//  Synchronous active-low reset: rotation returns to identity, no result held.
// ----------------------------------------------------------------------------
`default_nettype none

module givens_rotation_unit #(
    parameter int DATA_WIDTH = gru_pkg::DATA_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire gru_pkg::gru_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output gru_pkg::gru_out_t     m_data
);

    localparam int DW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int SH = 32 - DW;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (gru_pkg::FRAC_CS - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_SQRT, ST_HYP, ST_DIVC, ST_DIVS, ST_DONE
    } state_t;

    state_t                 state_reg;
    logic                   cmd_reg;
    logic signed [31:0]     a_reg, b_reg;
    logic signed [31:0]     cos_reg, sin_reg;
    logic signed [63:0]     prod_reg, acc0_reg, acc1_reg;
    logic [4:0]             cnt_reg;
    logic [63:0]            sq_s_reg, sq_r_reg;
    logic [31:0]            h_reg;
    logic                   m_valid_reg;
    gru_pkg::gru_out_t      out_reg;
    logic                   div_start_reg;
    logic [gru_pkg::DIV_NUM_W-1:0] div_num_reg;

    logic                   div_done;
    logic [gru_pkg::DIV_QUOT_W-1:0] div_quot;

    logic signed [31:0]     a_sh, b_sh, a_ext, b_ext;
    logic signed [31:0]     mul_x, mul_y;
    logic signed [63:0]     mul_p;
    logic [5:0]             bit_sh;
    logic [63:0]            bit_v, sq_sum;
    logic [63:0]            h_full;
    logic [31:0]            h_round;
    logic [31:0]            ma, mb;
    logic [gru_pkg::DIV_QUOT_W-1:0] q_clamp;
    logic signed [31:0]     q_pos, q_neg;
    logic signed [63:0]     rnd0, rnd1;
    logic signed [31:0]     r0, r1;
    logic                   out_free;

    function automatic logic signed [31:0] sat_dw(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return t[31:0];
    endfunction

    assign a_sh  = s_data.first_in <<< SH;
    assign b_sh  = s_data.second_in <<< SH;
    assign a_ext = a_sh >>> SH;
    assign b_ext = b_sh >>> SH;

    always_comb begin
        if (cmd_reg == gru_pkg::CMD_APPLY) begin
            mul_x = cnt_reg[0] ? sin_reg : cos_reg;
            mul_y = (cnt_reg[0] ^ cnt_reg[1]) ? b_reg : a_reg;
        end else begin
            mul_x = cnt_reg[0] ? b_reg : a_reg;
            mul_y = mul_x;
        end
    end
    assign mul_p = mul_x * mul_y;

    // one square-root digit per cycle
    assign bit_sh  = 6'd62 - {cnt_reg, 1'b0};
    assign bit_v   = 64'd1 << bit_sh;
    assign sq_sum  = sq_r_reg + bit_v;
    assign h_full  = (sq_s_reg > sq_r_reg) ? (sq_r_reg + 64'd1) : sq_r_reg;
    assign h_round = h_full[31:0];

    assign ma = a_reg[31] ? 32'(-a_reg) : a_reg;
    assign mb = b_reg[31] ? 32'(-b_reg) : b_reg;

    assign q_clamp = (div_quot > gru_pkg::DIV_QUOT_W'(gru_pkg::ONE_Q30))
                   ? gru_pkg::DIV_QUOT_W'(gru_pkg::ONE_Q30) : div_quot;
    assign q_pos   = {1'b0, q_clamp};
    assign q_neg   = -q_pos;

    assign rnd0 = (acc0_reg + RND_HALF) >>> gru_pkg::FRAC_CS;
    assign rnd1 = (acc1_reg + RND_HALF) >>> gru_pkg::FRAC_CS;

    always_comb begin
        if (cmd_reg == gru_pkg::CMD_APPLY) begin
            r0 = sat_dw(rnd0);
            r1 = sat_dw(rnd1);
        end else begin
            r0 = sat_dw($signed({32'd0, h_reg}));
            r1 = '0;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cos_reg       <= gru_pkg::ONE_Q30;
            sin_reg       <= '0;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            cnt_reg       <= '0;
            cmd_reg       <= gru_pkg::CMD_COMPUTE;
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_data.command;
                        a_reg     <= a_ext;
                        b_reg     <= b_ext;
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg <= mul_p;
                    cnt_reg  <= cnt_reg + 5'd1;
                    case (cnt_reg[1:0])
                        2'd1: acc0_reg <= prod_reg;
                        2'd2: acc0_reg <= acc0_reg + prod_reg;
                        2'd3: acc1_reg <= prod_reg;
                        default: ;
                    endcase
                    if ((cmd_reg == gru_pkg::CMD_APPLY && cnt_reg[1:0] == 2'd3) ||
                        (cmd_reg == gru_pkg::CMD_COMPUTE && cnt_reg[1:0] == 2'd1)) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    cnt_reg <= '0;
                    if (cmd_reg == gru_pkg::CMD_APPLY) begin
                        acc1_reg  <= acc1_reg - prod_reg;
                        state_reg <= ST_DONE;
                    end else begin
                        sq_s_reg  <= acc0_reg + prod_reg;
                        sq_r_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_s_reg >= sq_sum) begin
                        sq_s_reg <= sq_s_reg - sq_sum;
                        sq_r_reg <= (sq_r_reg >> 1) + bit_v;
                    end else begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= ST_HYP;
                    end
                end
                ST_HYP: begin
                    h_reg <= h_round;
                    if (h_round == 32'd0) begin
                        cos_reg   <= gru_pkg::ONE_Q30;
                        sin_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        div_num_reg   <= {ma, 30'd0} + {31'd0, h_round[31:1]};
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVC;
                    end
                end
                ST_DIVC: begin
                    if (div_done) begin
                        cos_reg       <= a_reg[31] ? q_neg : q_pos;
                        div_num_reg   <= {mb, 30'd0} + {31'd0, h_reg[31:1]};
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVS;
                    end
                end
                ST_DIVS: begin
                    if (div_done) begin
                        sin_reg   <= b_reg[31] ? q_neg : q_pos;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_reg.first_out  <= r0;
                        out_reg.second_out <= r1;
                        out_reg.cos_out    <= cos_reg;
                        out_reg.sin_out    <= sin_reg;
                        m_valid_reg        <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    gru_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (h_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second item while busy");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVC || state_reg == ST_DIVS))
        else $error("divider finished outside a division step");

    a_cos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cos_reg <= gru_pkg::ONE_Q30 && cos_reg >= -gru_pkg::ONE_Q30)
        else $error("cosine out of range");

    a_compute_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free && cmd_reg == gru_pkg::CMD_COMPUTE
        |=> m_valid && m_data.second_out == 32'sd0)
        else $error("compute item gave nonzero lower element");
`endif

endmodule

`default_nettype wire

// File: bench/givens_rotation_checker.sv
// ----------------------------------------------------------------------------
// givens_rotation_checker: result predictor and comparator
// Watches both channels, models the stored rotation, compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module givens_rotation_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire gru_pkg::gru_in_t  s_data,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire gru_pkg::gru_out_t m_data,
    output int                     fail_count,
    output int                     pending
);

    localparam longint DMAX = 64'sd2147483647;
    localparam longint DMIN = -64'sd2147483648;

    logic signed [63:0] rot_cos;
    logic signed [63:0] rot_sin;
    gru_pkg::gru_out_t  rotated_q[$];

    function automatic longint clamp_data(input longint v);
        if (v > DMAX) return DMAX;
        if (v < DMIN) return DMIN;
        return v;
    endfunction

    function automatic longint round_to_q16(input longint t);
        longint u;
        u = t + (64'sd1 <<< 29);
        return u >>> 30;
    endfunction

    function automatic logic [63:0] root_nearest(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r = 0;
        b = 64'd1 << 62;
        rem = s;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (rem > r) r = r + 1;
        return r;
    endfunction

    function automatic longint unit_ratio(input longint num, input logic [63:0] h);
        logic [63:0] n;
        logic [63:0] q;
        n = num < 0 ? -num : num;
        q = ((n << 30) + (h >> 1)) / h;
        if (q > 64'd1073741824) q = 64'd1073741824;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_rotation(input gru_pkg::gru_in_t it);
        longint            a;
        longint            b;
        logic [63:0]       h;
        gru_pkg::gru_out_t r;
        a = it.first_in;
        b = it.second_in;
        if (it.command == gru_pkg::CMD_COMPUTE) begin
            h = root_nearest(a * a + b * b);
            if (h == 0) begin
                rot_cos = 64'sd1073741824;
                rot_sin = 0;
            end else begin
                rot_cos = unit_ratio(a, h);
                rot_sin = unit_ratio(b, h);
            end
            r.first_out  = 32'(clamp_data(longint'(h)));
            r.second_out = '0;
        end else begin
            r.first_out  = 32'(clamp_data(round_to_q16(rot_cos * a + rot_sin * b)));
            r.second_out = 32'(clamp_data(round_to_q16(rot_cos * b - rot_sin * a)));
        end
        r.cos_out = rot_cos[31:0];
        r.sin_out = rot_sin[31:0];
        rotated_q.push_back(r);
    endtask

    assign pending = rotated_q.size();

    always @(posedge aclk) begin
        gru_pkg::gru_out_t want;
        if (!aresetn) begin
            rot_cos = 64'sd1073741824;
            rot_sin = 0;
            fail_count <= 0;
            rotated_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (rotated_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected item %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = rotated_q.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display("mismatch exp %h %h %h %h got %h %h %h %h",
                                want.first_out, want.second_out, want.cos_out,
                                want.sin_out, m_data.first_out, m_data.second_out,
                                m_data.cos_out, m_data.sin_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_rotation(s_data);
        end
    end

endmodule

`default_nettype wire

// File: bench/givens_rotation_unit_tb.sv
// ----------------------------------------------------------------------------
// givens_rotation_unit_tb: testbench top
// Directed corner items then random compute/apply runs with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module givens_rotation_unit_tb;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    gru_pkg::gru_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    gru_pkg::gru_out_t m_data;
    int                fail_count;
    int                pending;
    int                cycle_count;
    int                stall_left;

    givens_rotation_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    givens_rotation_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("givens_rotation_unit_tb: errors");
            $finish;
        end
    end

    // result side back-pressure, fresh wait per item, sometimes none
    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_ready <= 0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else if (m_valid && m_ready) begin
            draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            stall_left <= draw;
            m_ready <= (draw == 0);
        end else begin
            m_ready <= 1;
        end
    end

    function automatic logic signed [31:0] rand_data();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sd131072;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_rotation(input logic cmd, input logic signed [31:0] a,
                                 input logic signed [31:0] b, input int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= '{command: cmd, first_in: a, second_in: b};
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        int gap;
        cycle_count = 0;
        aresetn = 0;
        s_valid = 0;
        s_data  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        // identity before any compute, zero pivots, extremes, halves
        send_rotation(gru_pkg::CMD_APPLY, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_rotation(gru_pkg::CMD_COMPUTE, 0, 0, 0);
        send_rotation(gru_pkg::CMD_APPLY, 32'sh0001_0000, -32'sh0001_0000, 0);
        send_rotation(gru_pkg::CMD_COMPUTE, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_rotation(gru_pkg::CMD_APPLY, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_rotation(gru_pkg::CMD_APPLY, 32'sh8000_0000, 32'sh7fff_ffff, 0);
        send_rotation(gru_pkg::CMD_COMPUTE, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_rotation(gru_pkg::CMD_APPLY, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_rotation(gru_pkg::CMD_COMPUTE, 32'sh8000_0000, 0, 0);
        send_rotation(gru_pkg::CMD_APPLY, 32'sh8000_0000, 32'sh0000_0001, 0);
        send_rotation(gru_pkg::CMD_COMPUTE, 0, -32'sd3, 0);
        send_rotation(gru_pkg::CMD_APPLY, 32'sd1, -32'sd1, 0);
        send_rotation(gru_pkg::CMD_COMPUTE, 32'sd3, 32'sd4, 0);
        send_rotation(gru_pkg::CMD_APPLY, -32'sd1, 32'sd1, 0);
        send_rotation(gru_pkg::CMD_COMPUTE, -32'sd1, 32'sd1, 0);
        send_rotation(gru_pkg::CMD_APPLY, 32'sh0002_0000, 32'sh0003_0000, 0);
        // random QR sweeps: each item is a compute one time in five, else an apply
        for (int n = 0; n < 1150; n++) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            send_rotation(($urandom_range(0, 4) == 0) ? gru_pkg::CMD_COMPUTE
                                                      : gru_pkg::CMD_APPLY,
                          rand_data(), rand_data(), gap);
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (fail_count == 0)
            $display("givens_rotation_unit_tb: clean");
        else
            $display("givens_rotation_unit_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
